@@ hdl/acpu_pkg.sv @@
`timescale 1ns / 1ps

package acpu_pkg;

    localparam int DATA_W  = 32;
    localparam int OPND_W  = 12;
    localparam int MAG_W   = OPND_W - 1;
    localparam int SHAMT_W = 5;

    typedef enum logic [7:0] {
        OPC_ADD    = 8'd1,
        OPC_SHIFT  = 8'd2,
        OPC_NOP    = 8'd3,
        OPC_JUMP   = 8'd4,
        OPC_ZJUMP  = 8'd5,
        OPC_WRITE  = 8'd6,
        OPC_READ   = 8'd7,
        OPC_INC    = 8'd8,
        OPC_HALT   = 8'd9,
        OPC_MEMADD = 8'd10
    } opcode_t;

    typedef enum logic {
        KIND_EXEC    = 1'b0,
        KIND_RESTART = 1'b1
    } kind_t;

    typedef enum logic {
        REG_START_PC  = 1'b0,
        REG_START_ACC = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        kind_t               kind;
        logic [DATA_W-1:0]   instruction_word;
        logic signed [DATA_W-1:0] read_data;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0]        pc;
        logic signed [DATA_W-1:0] accumulator;
        logic                     mem_read;
        logic                     mem_write;
        logic signed [OPND_W-1:0] mem_address;
        logic signed [DATA_W-1:0] write_data;
        logic                     halted;
    } out_t;

    typedef struct packed {
        logic [DATA_W-1:0] pc;
        logic [DATA_W-1:0] acc;
        logic              halted;
    } arch_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] start_pc;
        logic [DATA_W-1:0] start_acc;
    } start_cfg_t;

    // sign-magnitude operand to 32-bit two's complement
    function automatic logic [DATA_W-1:0] sm_decode(input logic [OPND_W-1:0] field);
        logic [DATA_W-1:0] mag;
        mag = {{(DATA_W-MAG_W){1'b0}}, field[MAG_W-1:0]};
        return field[OPND_W-1] ? (~mag + 1'b1) : mag;
    endfunction

endpackage

@@ hdl/acpu_in_reg.sv @@
`timescale 1ns / 1ps

module acpu_in_reg
    import acpu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    input  logic advance,
    output logic item_valid,
    output in_t  item
);

    logic valid_reg;
    logic valid_next;
    in_t  item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // load on transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hdl/acpu_execute.sv @@
`timescale 1ns / 1ps

module acpu_execute
    import acpu_pkg::*;
(
    input  in_t         item,
    input  arch_state_t cur,
    input  start_cfg_t  cfg,
    output arch_state_t nxt,
    output out_t        result
);

    opcode_t           opc;
    logic [DATA_W-1:0] op1;
    logic [DATA_W-1:0] op2;
    logic [MAG_W-1:0]  mag1;
    logic              left;
    logic              big;
    logic [DATA_W-1:0] shifted;
    logic [DATA_W-1:0] pc_step;

    assign opc     = opcode_t'(item.instruction_word[31:24]);
    assign op1     = sm_decode(item.instruction_word[2*OPND_W-1:OPND_W]);
    assign op2     = sm_decode(item.instruction_word[OPND_W-1:0]);
    assign mag1    = item.instruction_word[OPND_W+MAG_W-1:OPND_W];
    assign left    = item.instruction_word[2*OPND_W-1] && (mag1 != '0);
    assign big     = mag1 >= MAG_W'(DATA_W);
    assign pc_step = cur.pc + DATA_W'(1);

    always_comb begin
        if (left) begin
            shifted = big ? '0 : (cur.acc << mag1[SHAMT_W-1:0]);
        end else if (big) begin
            shifted = {DATA_W{cur.acc[DATA_W-1]}};
        end else begin
            shifted = DATA_W'($signed(cur.acc) >>> mag1[SHAMT_W-1:0]);
        end
    end

    always_comb begin
        nxt                = cur;
        result.mem_read    = 1'b0;
        result.mem_write   = 1'b0;
        result.mem_address = '0;
        result.write_data  = '0;
        if (item.kind == KIND_RESTART) begin
            nxt.pc     = cfg.start_pc;
            nxt.acc    = cfg.start_acc;
            nxt.halted = 1'b0;
        end else if (!cur.halted) begin
            case (opc)
                OPC_ADD: begin
                    nxt.acc = op1 + op2;
                    nxt.pc  = pc_step;
                end
                OPC_SHIFT: begin
                    nxt.acc = shifted;
                    nxt.pc  = pc_step;
                end
                OPC_JUMP: begin
                    nxt.pc = cur.pc + op1;
                end
                OPC_ZJUMP: begin
                    nxt.pc = (cur.acc == '0) ? (cur.pc + op1) : pc_step;
                end
                OPC_WRITE: begin
                    result.mem_write   = 1'b1;
                    result.mem_address = op1[OPND_W-1:0];
                    result.write_data  = cur.acc;
                    nxt.pc             = pc_step;
                end
                OPC_READ: begin
                    result.mem_read    = 1'b1;
                    result.mem_address = op1[OPND_W-1:0];
                    nxt.acc            = item.read_data;
                    nxt.pc             = pc_step;
                end
                OPC_INC: begin
                    nxt.acc = cur.acc + op1;
                    nxt.pc  = pc_step;
                end
                OPC_HALT: begin
                    nxt.halted = 1'b1;
                end
                OPC_MEMADD: begin
                    result.mem_read    = 1'b1;
                    result.mem_address = op2[OPND_W-1:0];
                    nxt.acc            = op1 + item.read_data;
                    nxt.pc             = pc_step;
                end
                default: begin
                    nxt.pc = pc_step;
                end
            endcase
        end
        result.pc          = nxt.pc;
        result.accumulator = nxt.acc;
        result.halted      = nxt.halted;
    end

endmodule

@@ hdl/accumulator_cpu_execute_core.sv @@
// An input transfer loads the input register; the execute logic's result then loads the result register.
// Throughput: one instruction per cycle; input register, execute logic, result register.
// A stall on m_ready holds the result register and back-pressures through s_ready.
// Reset (aresetn low, synchronous): pc, accumulator, halted and both start registers clear
// to 0; input and result stages empty.
`timescale 1ns / 1ps

module accumulator_cpu_execute_core
    import acpu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cfg_reg_t              cfg_index,
    input  logic [DATA_W-1:0]     cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data
);

    logic        item_valid;
    in_t         item;
    logic        advance;
    arch_state_t state_reg;
    arch_state_t state_next;
    start_cfg_t  cfg_reg;
    out_t        result;
    out_t        out_reg;
    logic        out_valid_reg;

    assign advance = item_valid && (!out_valid_reg || m_ready);

    acpu_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    acpu_execute u_execute (
        .item   (item),
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .nxt    (state_next),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START_PC:  cfg_reg.start_pc  <= cfg_data;
                REG_START_ACC: cfg_reg.start_acc <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ hdl/acpu_checker.sv @@
`timescale 1ns / 1ps

module acpu_checker
    import acpu_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_halted_no_mem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.halted |-> !m_data.mem_read && !m_data.mem_write)
        else $error("memory access reported while halted");

    a_wdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.mem_write |-> m_data.write_data == '0)
        else $error("write data without write");

    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.mem_read && !m_data.mem_write |-> m_data.mem_address == '0)
        else $error("address without memory access");

endmodule

bind accumulator_cpu_execute_core acpu_checker u_acpu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
